// File: hdl/dvtu_pkg.sv
// Shared types and constants for the distance-vector table update block.
`timescale 1ns / 1ps
package dvtu_pkg;

  // Fixed field widths of the item ports
  localparam int ID_W        = 4;
  localparam int IN_COST_W   = 16;
  localparam int OUT_COST_W  = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER = 1'b1;
  localparam logic [ID_W-1:0]       OWN_ID_RESET   = '0;
  localparam logic [CFG_DATA_W-1:0] DIAMETER_RESET = 16'd16;

  // Item mode codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_ADVERT = 1'b1;

  // Parameter defaults
  localparam int DEF_ROUTERS   = 16;
  localparam int DEF_COST_BITS = 16;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming item and launch table reads
    logic commit;   // apply the update and load the result register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_stall;  // result register is full and not being taken
  } ctl_stat_t;

endpackage

// File: hdl/dvtu_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
module dvtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read ports, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: hdl/dvtu_ctrl.sv
// Controller: sequences one item through read and update phases.
`timescale 1ns / 1ps
module dvtu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  dvtu_pkg::ctl_stat_t stat,
  output dvtu_pkg::ctl_cmd_t  cmd
);

  import dvtu_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // Take a new item only between updates
  assign in_tready   = (state_r == ST_IDLE);
  assign cmd.capture = in_tvalid && (state_r == ST_IDLE);
  assign cmd.commit  = (state_r == ST_EXEC) && !stat.out_stall;

  // Advance on capture and commit
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/dvtu_dp.sv
// Datapath: routing table, relaxation logic, config registers and result register.
`timescale 1ns / 1ps
module dvtu_dp #(
  parameter int ROUTERS   = dvtu_pkg::DEF_ROUTERS,
  parameter int COST_BITS = dvtu_pkg::DEF_COST_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [dvtu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dvtu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // incoming item fields
  input  logic                                 in_mode,
  input  logic [dvtu_pkg::ID_W-1:0]            in_sender,
  input  logic [dvtu_pkg::ID_W-1:0]            in_target,
  input  logic [dvtu_pkg::IN_COST_W-1:0]       in_path_cost,
  input  logic                                 in_neighbor_flag,
  input  logic                                 in_last,
  // controller link
  input  dvtu_pkg::ctl_cmd_t                   cmd,
  output dvtu_pkg::ctl_stat_t                  stat,
  // result register
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_entry_changed,
  output logic                                 out_clamped,
  output logic [dvtu_pkg::OUT_COST_W-1:0]      out_route_cost,
  output logic [dvtu_pkg::ID_W-1:0]            out_next_hop,
  output logic                                 out_any_changed,
  output logic                                 out_done
);

  import dvtu_pkg::*;

  localparam int IDX_W  = $clog2(ROUTERS);
  localparam int WORD_W = COST_BITS + ID_W + 1;
  localparam int SUM_W  = ((COST_BITS > IN_COST_W) ? COST_BITS : IN_COST_W) + 1;
  localparam logic [COST_BITS-1:0] COST_MAX = '1;

  // Configuration registers
  logic [ID_W-1:0]       own_id_r;
  logic [CFG_DATA_W-1:0] diam_r;

  // Latched item
  logic                 it_mode_r;
  logic [ID_W-1:0]      it_snd_r;
  logic [ID_W-1:0]      it_tgt_r;
  logic [IN_COST_W-1:0] it_cost_r;
  logic                 it_nflag_r;
  logic                 it_last_r;

  // Per-entry flags: known mark and written mark (unwritten entries read zero)
  logic [ROUTERS-1:0] known_r;
  logic [ROUTERS-1:0] known_nxt;
  logic [ROUTERS-1:0] wvalid_r;
  logic [ROUTERS-1:0] wvalid_nxt;
  logic               msg_r;
  logic               msg_nxt;

  // Table memory
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] rd_snd_w;
  logic [WORD_W-1:0] rd_tgt_w;

  // Relaxation signals
  logic [IDX_W-1:0]     snd_a;
  logic [IDX_W-1:0]     tgt_a;
  logic                 in_range;
  logic [COST_BITS-1:0] snd_cost;
  logic [WORD_W-1:0]    tgt_word;
  logic [COST_BITS-1:0] old_cost;
  logic [ID_W-1:0]      old_hop;
  logic                 old_nb;
  logic                 tgt_known;
  logic [SUM_W-1:0]     sum_full;
  logic [COST_BITS-1:0] sum_sat;
  logic [COST_BITS-1:0] new_cost;
  logic [ID_W-1:0]      new_hop;
  logic                 new_nb;
  logic                 wr;
  logic                 changed;
  logic                 clamp;
  logic                 mark_snd;
  logic                 mark_tgt;
  logic                 any;

  // Result register
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  out_changed_r;
  logic                  out_clamped_r;
  logic [OUT_COST_W-1:0] out_cost_r;
  logic [ID_W-1:0]       out_hop_r;
  logic                  out_any_r;
  logic                  out_done_r;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= OWN_ID_RESET;
      diam_r   <= DIAMETER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_ID:   own_id_r <= cfg_wdata[ID_W-1:0];
        CFG_DIAMETER: diam_r   <= cfg_wdata;
        default:      own_id_r <= own_id_r;
      endcase
    end
  end

  // Hold the item for the update phase
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode_r  <= in_mode;
      it_snd_r   <= in_sender;
      it_tgt_r   <= in_target;
      it_cost_r  <= in_path_cost;
      it_nflag_r <= in_neighbor_flag;
      it_last_r  <= in_last;
    end
  end

  assign snd_a = IDX_W'(it_snd_r);
  assign tgt_a = IDX_W'(it_tgt_r);

  // Table: word is {neighbor, next hop, cost}; read both entries at capture
  dvtu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROUTERS)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (tgt_a),
    .wdata   (ram_wdata),
    .re      (cmd.capture),
    .raddr_a (IDX_W'(in_sender)),
    .raddr_b (IDX_W'(in_target)),
    .rdata_a (rd_snd_w),
    .rdata_b (rd_tgt_w)
  );

  // Unpack entries, unwritten ones read as zero
  assign in_range  = (32'(it_snd_r) < ROUTERS) && (32'(it_tgt_r) < ROUTERS);
  assign snd_cost  = wvalid_r[snd_a] ? rd_snd_w[COST_BITS-1:0] : '0;
  assign tgt_word  = wvalid_r[tgt_a] ? rd_tgt_w : '0;
  assign old_cost  = tgt_word[COST_BITS-1:0];
  assign old_hop   = tgt_word[COST_BITS +: ID_W];
  assign old_nb    = tgt_word[WORD_W-1];
  // the sender is marked known before the target is looked at
  assign tgt_known = known_r[tgt_a] || (it_snd_r == it_tgt_r);

  // Saturating path sum through the sender
  assign sum_full = SUM_W'(it_cost_r) + SUM_W'(snd_cost);
  assign sum_sat  = (sum_full > SUM_W'(COST_MAX)) ? COST_MAX : COST_BITS'(sum_full);

  // Relax the target entry
  always_comb begin
    new_cost = old_cost;
    new_hop  = old_hop;
    new_nb   = old_nb;
    wr       = 1'b0;
    changed  = 1'b0;
    clamp    = 1'b0;
    mark_snd = 1'b0;
    mark_tgt = 1'b0;
    if (in_range) begin
      if (it_mode_r == MODE_LOAD) begin
        new_cost = COST_BITS'(it_cost_r);
        new_hop  = it_snd_r;
        new_nb   = it_nflag_r;
        wr       = 1'b1;
        mark_tgt = 1'b1;
      end else begin
        mark_snd = 1'b1;
        if (it_tgt_r != own_id_r) begin
          priority if (!tgt_known) begin
            // learn a new destination
            new_cost = sum_sat;
            new_hop  = it_snd_r;
            wr       = 1'b1;
            changed  = 1'b1;
            mark_tgt = 1'b1;
          end else if ((old_hop == it_snd_r) && (old_cost != sum_sat)) begin
            // route through this sender follows its new sum
            wr = 1'b1;
            if (SUM_W'(sum_sat) > SUM_W'(diam_r)) begin
              new_cost = COST_BITS'(diam_r);
              clamp    = 1'b1;
            end else begin
              new_cost = sum_sat;
              changed  = 1'b1;
            end
          end else if (old_cost > sum_sat) begin
            // cheaper path replaces the route
            new_cost = sum_sat;
            new_hop  = it_snd_r;
            wr       = 1'b1;
            changed  = 1'b1;
          end else begin
            wr = 1'b0;
          end
        end
      end
    end
  end

  assign ram_we    = cmd.commit && wr;
  assign ram_wdata = {new_nb, new_hop, new_cost};

  // Advertisement change flag, cleared at the end of each advertisement
  assign any = it_last_r && (it_mode_r == MODE_ADVERT) && (msg_r || changed);

  always_comb begin
    msg_nxt    = msg_r;
    known_nxt  = known_r;
    wvalid_nxt = wvalid_r;
    if (cmd.commit) begin
      if (it_last_r) begin
        msg_nxt = 1'b0;
      end else if (changed) begin
        msg_nxt = 1'b1;
      end
      if (mark_snd) begin
        known_nxt[snd_a] = 1'b1;
      end
      if (mark_tgt) begin
        known_nxt[tgt_a] = 1'b1;
      end
      if (wr) begin
        wvalid_nxt[tgt_a] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_r    <= 1'b0;
      known_r  <= '0;
      wvalid_r <= '0;
    end else begin
      msg_r    <= msg_nxt;
      known_r  <= known_nxt;
      wvalid_r <= wvalid_nxt;
    end
  end

  // Result register: load on commit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_changed_r <= changed;
      out_clamped_r <= clamp;
      out_cost_r    <= in_range ? OUT_COST_W'(new_cost) : '0;
      out_hop_r     <= in_range ? new_hop : '0;
      out_any_r     <= any;
      out_done_r    <= it_last_r;
    end
  end

  assign stat.out_stall    = out_valid_r && !out_ready;
  assign out_valid         = out_valid_r;
  assign out_entry_changed = out_changed_r;
  assign out_clamped       = out_clamped_r;
  assign out_route_cost    = out_cost_r;
  assign out_next_hop      = out_hop_r;
  assign out_any_changed   = out_any_r;
  assign out_done          = out_done_r;

endmodule

// File: hdl/distance_vector_table_update.sv
// Top level of the distance-vector routing table update block.
// A result is loaded into the output register when its item commits; the commit waits
// while the previous result is still waiting in the output register.
// Items are taken one at a time, the next only after the last commits; each item reads the sender and target
// entries from the table memory, then does one read-modify-write of the target.
// A finished result waits in an output register while the next item is taken.
// Reset (synchronous, active low): all entries read as zero via per-entry
// written flags, no clearing pass; own id resets to 0, diameter limit to 16.
`timescale 1ns / 1ps
module distance_vector_table_update #(
  parameter int ROUTERS   = dvtu_pkg::DEF_ROUTERS,
  parameter int COST_BITS = dvtu_pkg::DEF_COST_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [dvtu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dvtu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input item stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: sender[3:0], target[7:4], path_cost[23:8], neighbor_flag[24], zero pad
  input  logic [dvtu_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: mode
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  // result item stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata: entry_changed[0], clamped[1], route_cost_out[17:2], next_hop_out[21:18],
  //        any_changed[22], zero pad
  output logic [dvtu_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast
);

  import dvtu_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  logic                  res_changed;
  logic                  res_clamped;
  logic [OUT_COST_W-1:0] res_cost;
  logic [ID_W-1:0]       res_hop;
  logic                  res_any;

  dvtu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dvtu_dp #(
    .ROUTERS   (ROUTERS),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_mode           (in_tuser),
    .in_sender         (in_tdata[3:0]),
    .in_target         (in_tdata[7:4]),
    .in_path_cost      (in_tdata[23:8]),
    .in_neighbor_flag  (in_tdata[24]),
    .in_last           (in_tlast),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_entry_changed (res_changed),
    .out_clamped       (res_clamped),
    .out_route_cost    (res_cost),
    .out_next_hop      (res_hop),
    .out_any_changed   (res_any),
    .out_done          (out_tlast)
  );

  // Pack the result fields, lowest field first
  assign out_tdata = {1'b0, res_any, res_hop, res_cost, res_clamped, res_changed};

endmodule

// File: tb/distance_vector_table_update_checker.sv
// Checker for the distance-vector table update block: table predictor and result compare.
`timescale 1ns / 1ps
module distance_vector_table_update_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dvtu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dvtu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [dvtu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [dvtu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  output int                               fail_count,
  output int                               pending,
  output int                               n_checked,
  output int                               n_changes,
  output int                               n_clamps,
  output int                               n_triggers
);

  import dvtu_pkg::*;

  typedef struct packed {
    logic        entry_changed;
    logic        clamped;
    logic [15:0] cost;
    logic [3:0]  hop;
    logic        any_changed;
    logic        done;
  } route_result_t;

  // Shadow routing table and registers
  logic        known [16];
  logic [15:0] route_cost [16];
  logic [3:0]  hop_of [16];
  logic        advert_changed;
  logic [3:0]  own_id;
  logic [15:0] diameter;

  route_result_t results_due[$];

  // Relax one item against the shadow table and return the result it causes
  function automatic route_result_t relax_route(input logic mode, input logic [3:0] snd,
                                                input logic [3:0] tgt, input logic [15:0] cost,
                                                input logic is_last);
    route_result_t r;
    logic [16:0]   wide_sum;
    logic [15:0]   sum;
    r = '0;
    if (mode == MODE_LOAD) begin
      known[tgt]      = 1'b1;
      route_cost[tgt] = cost;
      hop_of[tgt]     = snd;
    end else begin
      known[snd] = 1'b1;
      wide_sum   = {1'b0, cost} + {1'b0, route_cost[snd]};
      sum        = wide_sum[16] ? 16'hFFFF : wide_sum[15:0];
      if (tgt != own_id) begin
        if (!known[tgt]) begin
          // learn a new destination
          known[tgt]      = 1'b1;
          route_cost[tgt] = sum;
          hop_of[tgt]     = snd;
          r.entry_changed = 1'b1;
        end else if (hop_of[tgt] == snd && route_cost[tgt] != sum) begin
          // follow the current next hop, clamp at the diameter
          if (sum > diameter) begin
            route_cost[tgt] = diameter;
            r.clamped       = 1'b1;
          end else begin
            route_cost[tgt] = sum;
            r.entry_changed = 1'b1;
          end
        end else if (route_cost[tgt] > sum) begin
          // take the cheaper path
          route_cost[tgt] = sum;
          hop_of[tgt]     = snd;
          r.entry_changed = 1'b1;
        end
      end
      if (r.entry_changed) advert_changed = 1'b1;
    end
    r.cost = route_cost[tgt];
    r.hop  = hop_of[tgt];
    if (is_last) begin
      r.any_changed  = (mode != MODE_LOAD) && advert_changed;
      advert_changed = 1'b0;
    end
    r.done = is_last;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
  endtask

  assign pending = results_due.size();

  always @(posedge clk) begin
    route_result_t want;
    route_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        known[i]      = 1'b0;
        route_cost[i] = '0;
        hop_of[i]     = '0;
      end
      advert_changed = 1'b0;
      own_id         = OWN_ID_RESET;
      diameter       = DIAMETER_RESET;
      results_due.delete();
      fail_count = 0;
      n_checked  = 0;
      n_changes  = 0;
      n_clamps   = 0;
      n_triggers = 0;
    end else begin
      // track register writes
      if (cfg_we) begin
        if (cfg_index == CFG_OWN_ID) own_id = cfg_wdata[ID_W-1:0];
        else if (cfg_index == CFG_DIAMETER) diameter = cfg_wdata;
      end
      // compare the result against the oldest expectation
      if (out_tvalid && out_tready) begin
        got.entry_changed = out_tdata[0];
        got.clamped       = out_tdata[1];
        got.cost          = out_tdata[17:2];
        got.hop           = out_tdata[21:18];
        got.any_changed   = out_tdata[22];
        got.done          = out_tlast;
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result item", 0, 1);
        end else begin
          want = results_due.pop_front();
          n_checked++;
          if (want.entry_changed) n_changes++;
          if (want.clamped) n_clamps++;
          if (want.any_changed) n_triggers++;
          if (got.entry_changed != want.entry_changed)
            report_mismatch("entry_changed", want.entry_changed, got.entry_changed);
          if (got.clamped != want.clamped)
            report_mismatch("clamped", want.clamped, got.clamped);
          if (got.cost != want.cost)
            report_mismatch("route_cost_out", want.cost, got.cost);
          if (got.hop != want.hop)
            report_mismatch("next_hop_out", want.hop, got.hop);
          if (got.any_changed != want.any_changed)
            report_mismatch("any_changed", want.any_changed, got.any_changed);
          if (got.done != want.done)
            report_mismatch("done_res", want.done, got.done);
        end
      end
      // predict each accepted item
      if (in_tvalid && in_tready)
        results_due.push_back(relax_route(in_tuser, in_tdata[3:0], in_tdata[7:4],
                                          in_tdata[23:8], in_tlast));
    end
  end

endmodule

// File: tb/distance_vector_table_update_tb.sv
// Testbench top for the distance-vector table update block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module distance_vector_table_update_tb;
  import dvtu_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 135;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  // tdata: sender, target, path_cost, neighbor_flag, zero pad
  logic [IN_TDATA_W-1:0]  in_tdata;
  // tuser: mode
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  // tdata: entry_changed, clamped, route_cost_out, next_hop_out, any_changed, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  int fail_count, pending, n_checked, n_changes, n_clamps, n_triggers;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_ticket = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  logic [3:0]  cur_own_id = OWN_ID_RESET;

  distance_vector_table_update uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  distance_vector_table_update_checker route_chk (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .fail_count, .pending, .n_checked, .n_changes, .n_clamps, .n_triggers
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left   = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_ticket) begin
        hold_served = hold_ticket;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("** distance_vector_table_update: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_item(input logic mode, input logic [3:0] snd, input logic [3:0] tgt,
                           input logic [15:0] cost, input logic nflag, input logic is_last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tlast  <= is_last;
    in_tdata  <= {7'd0, nflag, cost, tgt, snd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Wait until every result is back, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == CFG_OWN_ID) cur_own_id = val[3:0];
  endtask

  // Mostly small costs around the diameter, sometimes the full range
  function automatic logic [15:0] pick_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 16'($urandom_range(0, 12));
    if (r < 82) return 16'($urandom_range(0, 40));
    if (r < 95) return 16'($urandom);
    return 16'hFFFF - 16'($urandom_range(0, 2));
  endfunction

  function automatic logic [3:0] pick_target();
    if ($urandom_range(0, 99) < 12) return cur_own_id;
    return 4'($urandom_range(0, 15));
  endfunction

  // One random burst: a table load, a noise item, or an advertisement
  task automatic random_burst();
    int         r;
    int         npairs;
    logic [3:0] snd;
    logic       drop_end;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_item(MODE_LOAD, 4'($urandom), 4'($urandom), pick_cost(), 1'($urandom),
                $urandom_range(0, 3) == 0);
    end else if (r < 18) begin
      send_item(1'($urandom), 4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom),
                1'($urandom));
    end else begin
      snd      = 4'($urandom);
      npairs   = $urandom_range(1, 6);
      drop_end = ($urandom_range(0, 99) < 10);
      for (int i = 0; i < npairs; i++)
        send_item(MODE_ADVERT, snd, pick_target(), pick_cost(), 1'($urandom),
                  (i == npairs - 1) && !drop_end);
    end
  endtask

  initial begin
    int own_ids [PHASES];
    int diameters [PHASES];
    int stop_at;
    own_ids   = '{3, 15, 0, 9, 5, 12, 0, $urandom_range(0, 15)};
    diameters = '{16, 0, 65535, 8, 30, 1, 16, $urandom_range(2, 60)};
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_OWN_ID;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= MODE_LOAD;
    in_tlast  <= 1'b0;
    in_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings: own id 0, diameter 16
    send_item(MODE_LOAD, 4'd1, 4'd1, 16'd3, 1'b1, 1'b0);
    send_item(MODE_LOAD, 4'd2, 4'd2, 16'd0, 1'b1, 1'b0);
    send_item(MODE_LOAD, 4'd3, 4'd3, 16'hFFFF, 1'b0, 1'b0);
    send_item(MODE_LOAD, 4'd15, 4'd15, 16'h5A5A, 1'b0, 1'b0);
    // learn, skip own entry, clamp, follow the next hop, end with a change
    send_item(MODE_ADVERT, 4'd1, 4'd5, 16'd4, 1'b0, 1'b0);
    send_item(MODE_ADVERT, 4'd1, 4'd0, 16'd1, 1'b1, 1'b0);
    send_item(MODE_ADVERT, 4'd1, 4'd5, 16'd20, 1'b0, 1'b0);
    send_item(MODE_ADVERT, 4'd1, 4'd5, 16'd2, 1'b0, 1'b1);
    // cheaper path through another sender
    send_item(MODE_ADVERT, 4'd2, 4'd5, 16'd1, 1'b0, 1'b1);
    // unknown sender and saturating sums
    send_item(MODE_ADVERT, 4'd9, 4'd10, 16'hFFFF, 1'b1, 1'b0);
    send_item(MODE_ADVERT, 4'd9, 4'd10, 16'hFFFF, 1'b0, 1'b1);
    send_item(MODE_ADVERT, 4'd3, 4'd11, 16'hFFFF, 1'b0, 1'b0);
    send_item(MODE_ADVERT, 4'd3, 4'd11, 16'd1, 1'b0, 1'b0);
    // load with last ends the advertisement and drops its change flag
    send_item(MODE_LOAD, 4'd0, 4'd4, 16'hA5A5, 1'b1, 1'b1);
    // advertisement that ends without a change
    send_item(MODE_ADVERT, 4'd3, 4'd3, 16'd0, 1'b0, 1'b1);
    send_item(MODE_ADVERT, 4'd15, 4'd0, 16'hFFFF, 1'b1, 1'b1);
    send_item(MODE_ADVERT, 4'd15, 4'd15, 16'd0, 1'b0, 1'b0);
    send_item(MODE_ADVERT, 4'd0, 4'd14, 16'h8000, 1'b1, 1'b1);

    // Random phases over register settings and idling patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(CFG_OWN_ID, 16'(own_ids[ph]));
      write_reg(CFG_DIAMETER, 16'(diameters[ph]));
      case (ph % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 57;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 57;
        end
        default: begin
          tx_idle_pct  = 36;
          rx_stall_pct = 36;
        end
      endcase
      // long result hold-off while the sender keeps offering
      if (ph == 2) hold_ticket++;
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) random_burst();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Run covered %0d items over %0d register settings: %0d route changes,",
             items_sent, PHASES + 1, n_changes);
    $display("%0d diameter clamps and %0d resend triggers checked in %0d results.",
             n_clamps, n_triggers, n_checked);
    if (fail_count == 0) begin
      $display("** distance_vector_table_update: PASSED **");
    end else begin
      $display("** distance_vector_table_update: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/dvtu_pkg.sv
hdl/dvtu_ram.sv
hdl/dvtu_ctrl.sv
hdl/dvtu_dp.sv
hdl/distance_vector_table_update.sv
tb/distance_vector_table_update_checker.sv
tb/distance_vector_table_update_tb.sv
